@@ rtl/core/olid_pkg.sv @@
package olid_pkg;

	// Default list depth.
	localparam int CAPACITY_DEFAULT = 64;

	// Fixed field widths of the command and response words.
	localparam int VALUE_W    = 32;
	localparam int POSITION_W = 16;
	localparam int STATUS_W   = 2;
	localparam int INDEX_W    = 7;
	localparam int LENGTH_W   = 7;

	// Operation codes.
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REMOVED   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

	// Command word.
	typedef struct packed {
		logic                        operation;
		logic signed [VALUE_W-1:0]   value;
		logic [POSITION_W-1:0]       position;
	} cmd_word_t;

	// Response word.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0]  index;
		logic [LENGTH_W-1:0] length;
	} rsp_word_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_WAIT
	} state_t;

	// Commands broadcast to every cell of the chain.
	typedef enum logic [2:0] {
		C_HOLD,
		C_INSERT,
		C_REMOVE,
		C_START,
		C_STEP
	} cell_cmd_t;

	// Control broadcast from the controller to the cells.
	typedef struct packed {
		cell_cmd_t                 cmd;
		logic signed [VALUE_W-1:0] data;
	} cell_ctrl_t;

endpackage

@@ rtl/core/olid_cell.sv @@
module olid_cell #(
	parameter int CAPACITY = olid_pkg::CAPACITY_DEFAULT,
	parameter int IDX      = 0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  olid_pkg::cell_ctrl_t                ctrl,
	input  logic [$clog2(CAPACITY)-1:0]         slot,
	input  logic signed [olid_pkg::VALUE_W-1:0] prev_entry,
	input  logic signed [olid_pkg::VALUE_W-1:0] next_entry,
	input  logic                                prev_wave,
	output logic signed [olid_pkg::VALUE_W-1:0] entry,
	output logic                                wave,
	output logic                                hit
);
	import olid_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic signed [VALUE_W-1:0] entry_q;
	logic                      wave_q;
	logic                      passed_q;

	// Entry storage: take the new value, shift up on insert, close the gap on remove.
	always_ff @(posedge clk) begin
		unique case (ctrl.cmd)
			C_INSERT: begin
				if (slot == MY_IDX) begin
					entry_q <= ctrl.data;
				end else if (MY_IDX > slot) begin
					entry_q <= prev_entry;
				end
			end
			C_REMOVE: begin
				if (!passed_q && (IDX < CAPACITY - 1)) begin
					entry_q <= next_entry;
				end
			end
			default: begin
			end
		endcase
	end

	// Search token and the mark left behind as it moves up the chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q   <= 1'b0;
			passed_q <= 1'b0;
		end else begin
			unique case (ctrl.cmd)
				C_START: begin
					wave_q   <= (IDX == 0);
					passed_q <= 1'b0;
				end
				C_STEP: begin
					if (wave_q) begin
						passed_q <= 1'b1;
					end
					wave_q <= prev_wave;
				end
				C_REMOVE: begin
					wave_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	assign entry = entry_q;
	assign wave  = wave_q;
	assign hit   = wave_q && (entry_q == ctrl.data);

endmodule

@@ rtl/core/ordered_list_insert_delete_core.sv @@
// Ordered list of up to CAPACITY signed 32-bit values, kept in a chain of cells.
// Command channel: cmd, cmd_valid, cmd_stall. A word moves when valid is high and
// stall is low. An insert places the value at a 1-based position (position 0 acts
// as 2, a position past the end appends); a delete removes the first equal entry.
// Response channel: rsp, rsp_valid, rsp_stall, one word per command with status,
// touched index and the new length.
// Operation: an insert completes in the cycle it is taken and its response is
// registered. A delete walks a search token up the chain, one cell per cycle,
// until the key is found or the last entry is checked; once the key is found,
// the entries above it shift down to close the gap.
// Throughput: one insert per cycle while responses drain; a delete occupies the
// chain until its token stops.
// The controller takes a new command while an earlier response still waits in the
// output register; if the receiver stalls, the next finished response is parked
// and cmd_stall stays high until it moves to the output register.
// Reset empties the list at once; entry contents are not cleared.
module ordered_list_insert_delete_core #(
	parameter int CAPACITY = olid_pkg::CAPACITY_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  olid_pkg::cmd_word_t cmd,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	output olid_pkg::rsp_word_t rsp,
	output logic                rsp_valid,
	input  logic                rsp_stall
);
	import olid_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic [IW-1:0]   scan_q, scan_d;
	rsp_word_t       res_q;
	rsp_word_t       rsp_q;
	logic            rsp_valid_q;
	logic signed [VALUE_W-1:0] key_q;

	logic            accept;
	logic            out_free;
	logic            done;
	rsp_word_t       done_word;
	cell_ctrl_t      ctrl;
	logic [IW-1:0]   slot;
	logic [POSITION_W-1:0] want;
	logic            any_hit;

	logic signed [VALUE_W-1:0] entry_w [CAPACITY];
	logic [CAPACITY-1:0]       wave_w;
	logic [CAPACITY-1:0]       hit_w;

	assign cmd_stall = (state_q != S_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign any_hit   = |hit_w;

	// Insert slot: position 1 is the front, 0 acts as 2, past the end appends.
	always_comb begin
		priority if (cmd.position == POSITION_W'(1)) begin
			want = '0;
		end else if (cmd.position == '0) begin
			want = POSITION_W'(1);
		end else begin
			want = cmd.position - POSITION_W'(1);
		end
		if (32'(want) > 32'(count_q)) begin
			slot = IW'(count_q);
		end else begin
			slot = IW'(want);
		end
	end

	// Cell commands and finished responses.
	always_comb begin
		ctrl.cmd  = C_HOLD;
		ctrl.data = key_q;
		done      = 1'b0;
		done_word = '0;
		count_d   = count_q;
		scan_d    = scan_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cmd.operation == OP_INSERT) begin
						done = 1'b1;
						if (32'(count_q) >= CAPACITY) begin
							done_word.status = ST_FULL;
							done_word.length = LENGTH_W'(count_q);
						end else begin
							ctrl.cmd         = C_INSERT;
							ctrl.data        = cmd.value;
							count_d          = count_q + CW'(1);
							done_word.status = ST_INSERTED;
							done_word.index  = INDEX_W'(slot);
							done_word.length = LENGTH_W'(count_d);
						end
					end else if (count_q == '0) begin
						done             = 1'b1;
						done_word.status = ST_NOT_FOUND;
						done_word.length = LENGTH_W'(count_q);
					end else begin
						ctrl.cmd = C_START;
						scan_d   = '0;
					end
				end
			end
			S_SCAN: begin
				if (any_hit) begin
					ctrl.cmd         = C_REMOVE;
					count_d          = count_q - CW'(1);
					done             = 1'b1;
					done_word.status = ST_REMOVED;
					done_word.index  = INDEX_W'(scan_q);
					done_word.length = LENGTH_W'(count_d);
				end else if (CW'(scan_q) + CW'(1) == count_q) begin
					done             = 1'b1;
					done_word.status = ST_NOT_FOUND;
					done_word.length = LENGTH_W'(count_q);
				end else begin
					ctrl.cmd = C_STEP;
					scan_d   = scan_q + IW'(1);
				end
			end
			S_WAIT: begin
			end
			default: begin
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && cmd.operation == OP_DELETE && count_q != '0) begin
					state_d = S_SCAN;
				end else if (done && !out_free) begin
					state_d = S_WAIT;
				end
			end
			S_SCAN: begin
				if (done) begin
					state_d = out_free ? S_IDLE : S_WAIT;
				end
			end
			S_WAIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			scan_q  <= scan_d;
			if (done && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (state_q == S_WAIT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: search key, parked response and output word.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= cmd.value;
		end
		if (done && !out_free) begin
			res_q <= done_word;
		end
		if (done && out_free) begin
			rsp_q <= done_word;
		end else if (state_q == S_WAIT && out_free) begin
			rsp_q <= res_q;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	// The chain of cells.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VALUE_W-1:0] prev_e;
		logic signed [VALUE_W-1:0] next_e;
		logic                      prev_w;

		if (i == 0) begin : g_first
			assign prev_e = '0;
			assign prev_w = 1'b0;
		end else begin : g_mid
			assign prev_e = entry_w[i-1];
			assign prev_w = wave_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_e = '0;
		end else begin : g_next
			assign next_e = entry_w[i+1];
		end

		olid_cell #(
			.CAPACITY (CAPACITY),
			.IDX      (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.slot       (slot),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.prev_wave  (prev_w),
			.entry      (entry_w[i]),
			.wave       (wave_w[i]),
			.hit        (hit_w[i])
		);
	end

endmodule
